// ===== sv/h264sps_pkg.sv =====
// Package for the H.264 SPS dimension parser.
// Holds shared widths, result status codes, default limits and the parser status struct.
// No dependencies.
`default_nettype none

package h264sps_pkg;

  // Payload widths
  localparam int BYTE_W = 8;
  localparam int STAT_W = 2;
  localparam int PIC_W  = 17;
  // Block counts: the picture size is the block count times 16
  localparam int BLK_W  = PIC_W - 4;

  // Default limits
  localparam int DEF_MAX_LEADING_ZEROS = 31;
  localparam int DEF_MAX_DIM_BLOCKS    = 4096;
  localparam int DEF_MAX_POC_CYCLE     = 255;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOTSPS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_TRUNC  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd3;

  // Status the bit parser reports to the top level
  typedef struct packed {
    logic              given;   // result decided for this NAL
    logic [STAT_W-1:0] status;
    logic [BLK_W-1:0]  wib;     // width in macroblocks
    logic [BLK_W-1:0]  hib;     // height in map units
  } parse_res_t;

endpackage

`default_nettype wire

// ===== sv/h264sps_ifs.sv =====
// Handshake interfaces of the SPS dimension parser: byte input and result output.
// Depends on h264sps_pkg.
`default_nettype none

interface h264sps_in_if import h264sps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface h264sps_out_if import h264sps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [PIC_W-1:0]  pic_width;
  logic [PIC_W-1:0]  pic_height;

  modport source (output valid, output status, output pic_width, output pic_height,
                  input ready);
  modport sink   (input valid, input status, input pic_width, input pic_height,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/h264sps_bitparse.sv =====
// Bit-serial SPS syntax parser: one bit per cycle while bit_vld is high, fixed fields and Exp-Golomb codes.
// Depends on h264sps_pkg.
`default_nettype none

module h264sps_bitparse import h264sps_pkg::*; #(
  parameter int MAX_LEADING_ZEROS = DEF_MAX_LEADING_ZEROS,
  parameter int MAX_DIM_BLOCKS    = DEF_MAX_DIM_BLOCKS,
  parameter int MAX_POC_CYCLE     = DEF_MAX_POC_CYCLE
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic clr,      // end of NAL: back to header step
  input  wire logic bit_vld,
  input  wire logic bit_in,
  output parse_res_t res
);

  localparam int ACC_W = MAX_LEADING_ZEROS + 1;
  localparam int LZ_W  = $clog2(MAX_LEADING_ZEROS + 2);
  localparam int CYC_W = $clog2(MAX_POC_CYCLE + 1);
  localparam int ST_W  = 5;

  // Syntax element being read
  localparam logic [ST_W-1:0] ST_HDR        = 5'd0;
  localparam logic [ST_W-1:0] ST_PROFILE    = 5'd1;
  localparam logic [ST_W-1:0] ST_CONSTR     = 5'd2;
  localparam logic [ST_W-1:0] ST_LEVEL      = 5'd3;
  localparam logic [ST_W-1:0] ST_SPSID      = 5'd4;
  localparam logic [ST_W-1:0] ST_CHROMA     = 5'd5;
  localparam logic [ST_W-1:0] ST_RESID      = 5'd6;
  localparam logic [ST_W-1:0] ST_DEPTHL     = 5'd7;
  localparam logic [ST_W-1:0] ST_DEPTHC     = 5'd8;
  localparam logic [ST_W-1:0] ST_BYPASS     = 5'd9;
  localparam logic [ST_W-1:0] ST_MATRIX     = 5'd10;
  localparam logic [ST_W-1:0] ST_LISTFLAG   = 5'd11;
  localparam logic [ST_W-1:0] ST_DELTA      = 5'd12;
  localparam logic [ST_W-1:0] ST_FRAMENUM   = 5'd13;
  localparam logic [ST_W-1:0] ST_POCTYPE    = 5'd14;
  localparam logic [ST_W-1:0] ST_POCLSB     = 5'd15;
  localparam logic [ST_W-1:0] ST_ALWAYSZERO = 5'd16;
  localparam logic [ST_W-1:0] ST_OFFNONREF  = 5'd17;
  localparam logic [ST_W-1:0] ST_OFFTB      = 5'd18;
  localparam logic [ST_W-1:0] ST_NUMCYCLE   = 5'd19;
  localparam logic [ST_W-1:0] ST_CYCLEOFF   = 5'd20;
  localparam logic [ST_W-1:0] ST_NUMREF     = 5'd21;
  localparam logic [ST_W-1:0] ST_GAPS       = 5'd22;
  localparam logic [ST_W-1:0] ST_WIDTH      = 5'd23;
  localparam logic [ST_W-1:0] ST_HEIGHT     = 5'd24;
  localparam logic [ST_W-1:0] ST_DONE       = 5'd25;

  // High profiles carry chroma format, bit depths and scaling lists
  function automatic logic is_high(input logic [7:0] p);
    return p == 8'd100 || p == 8'd110 || p == 8'd122 || p == 8'd244 ||
           p == 8'd44  || p == 8'd83  || p == 8'd86  || p == 8'd118 ||
           p == 8'd128 || p == 8'd138 || p == 8'd144;
  endfunction

  logic [ST_W-1:0]  step_r, step_nxt;
  logic [LZ_W-1:0]  lzc_r, lzc_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [7:0]       prof_r, prof_nxt;
  logic [3:0]       list_r, list_nxt;
  logic [6:0]       coef_r, coef_nxt;
  logic [7:0]       last_scale_r, last_scale_nxt;
  logic [CYC_W-1:0] cyc_r, cyc_nxt;
  logic [BLK_W-1:0] wib_r, wib_nxt;
  logic [BLK_W-1:0] hib_r, hib_nxt;
  logic             given_r, given_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;

  logic             fix8, fix1, is_fixed;
  logic [ACC_W-1:0] acc_sh;
  logic [LZ_W-1:0]  lzc_inc, lzc_dec;
  logic             fin;
  logic [ACC_W-1:0] v;
  logic [7:0]       delta, ns;
  logic [6:0]       cn;
  logic             list_full;
  logic [3:0]       ln;
  logic [CYC_W-1:0] cyc_dec;

  assign fix8     = step_r == ST_HDR || step_r == ST_PROFILE || step_r == ST_CONSTR ||
                    step_r == ST_LEVEL;
  assign fix1     = step_r == ST_RESID || step_r == ST_BYPASS || step_r == ST_MATRIX ||
                    step_r == ST_LISTFLAG || step_r == ST_ALWAYSZERO || step_r == ST_GAPS;
  assign is_fixed = fix8 || fix1;
  assign acc_sh   = {acc_r[ACC_W-2:0], bit_in};
  assign lzc_inc  = lzc_r + 1'b1;
  assign lzc_dec  = lzc_r - 1'b1;

  // Scaling-list delta: se(v) reduced modulo 256
  assign delta     = v[0] ? (v[8:1] + 8'd1) : (8'd0 - v[8:1]);
  assign ns        = last_scale_r + delta;
  assign cn        = coef_r + 7'd1;
  assign list_full = (list_r < 4'd6) ? (cn >= 7'd16) : (cn >= 7'd64);
  assign ln        = list_r + 4'd1;
  assign cyc_dec   = cyc_r - 1'b1;

  // One bit through the current syntax element
  always_comb begin
    step_nxt       = step_r;
    lzc_nxt        = lzc_r;
    acc_nxt        = acc_r;
    prof_nxt       = prof_r;
    list_nxt       = list_r;
    coef_nxt       = coef_r;
    last_scale_nxt = last_scale_r;
    cyc_nxt        = cyc_r;
    wib_nxt        = wib_r;
    hib_nxt        = hib_r;
    given_nxt      = given_r;
    stat_nxt       = stat_r;
    fin            = 1'b0;
    v              = '0;

    if (bit_vld && !given_r && step_r < ST_DONE) begin
      if (is_fixed) begin
        acc_nxt = acc_sh;
        lzc_nxt = lzc_inc;
        if (fix8 ? (lzc_inc >= LZ_W'(8)) : 1'b1) begin
          fin = 1'b1;
          v   = acc_sh;
        end
      end else if (acc_r == '0) begin
        // prefix: count zeros up to the marker one
        if (!bit_in) begin
          lzc_nxt = lzc_inc;
          if (lzc_inc > LZ_W'(MAX_LEADING_ZEROS)) begin
            given_nxt = 1'b1;
            stat_nxt  = STAT_RANGE;
            step_nxt  = ST_DONE;
          end
        end else begin
          acc_nxt = ACC_W'(1);
          if (lzc_r == '0) begin
            fin = 1'b1;
            v   = '0;
          end
        end
      end else begin
        // suffix bits
        acc_nxt = acc_sh;
        lzc_nxt = lzc_dec;
        if (lzc_dec == '0) begin
          fin = 1'b1;
          v   = acc_sh - 1'b1;
        end
      end
    end

    // Element complete: act on its value
    if (fin) begin
      acc_nxt = '0;
      lzc_nxt = '0;
      case (step_r)
        ST_HDR: begin
          if (v[4:0] != 5'd7) begin
            given_nxt = 1'b1;
            stat_nxt  = STAT_NOTSPS;
            step_nxt  = ST_DONE;
          end else begin
            step_nxt = ST_PROFILE;
          end
        end
        ST_PROFILE: begin
          prof_nxt = v[7:0];
          step_nxt = ST_CONSTR;
        end
        ST_CONSTR:  step_nxt = ST_LEVEL;
        ST_LEVEL:   step_nxt = ST_SPSID;
        ST_SPSID:   step_nxt = is_high(prof_r) ? ST_CHROMA : ST_FRAMENUM;
        ST_CHROMA: begin
          // profile register now flags 4:4:4
          prof_nxt = (v == ACC_W'(3)) ? 8'd1 : 8'd0;
          step_nxt = (v == ACC_W'(3)) ? ST_RESID : ST_DEPTHL;
        end
        ST_RESID:   step_nxt = ST_DEPTHL;
        ST_DEPTHL:  step_nxt = ST_DEPTHC;
        ST_DEPTHC:  step_nxt = ST_BYPASS;
        ST_BYPASS:  step_nxt = ST_MATRIX;
        ST_MATRIX: begin
          list_nxt = '0;
          step_nxt = v[0] ? ST_LISTFLAG : ST_FRAMENUM;
        end
        ST_LISTFLAG: begin
          if (v[0]) begin
            coef_nxt       = '0;
            last_scale_nxt = 8'd8;
            step_nxt       = ST_DELTA;
          end else begin
            list_nxt = ln;
            step_nxt = (ln >= ((prof_r != 8'd0) ? 4'd12 : 4'd8)) ? ST_FRAMENUM : ST_LISTFLAG;
          end
        end
        ST_DELTA: begin
          coef_nxt = cn;
          if (ns == 8'd0 || list_full) begin
            list_nxt = ln;
            step_nxt = (ln >= ((prof_r != 8'd0) ? 4'd12 : 4'd8)) ? ST_FRAMENUM : ST_LISTFLAG;
          end else begin
            last_scale_nxt = ns;
          end
        end
        ST_FRAMENUM: step_nxt = ST_POCTYPE;
        ST_POCTYPE: begin
          if (v == '0)           step_nxt = ST_POCLSB;
          else if (v == ACC_W'(1)) step_nxt = ST_ALWAYSZERO;
          else                   step_nxt = ST_NUMREF;
        end
        ST_POCLSB:     step_nxt = ST_NUMREF;
        ST_ALWAYSZERO: step_nxt = ST_OFFNONREF;
        ST_OFFNONREF:  step_nxt = ST_OFFTB;
        ST_OFFTB:      step_nxt = ST_NUMCYCLE;
        ST_NUMCYCLE: begin
          if (v > ACC_W'(MAX_POC_CYCLE)) begin
            given_nxt = 1'b1;
            stat_nxt  = STAT_RANGE;
            step_nxt  = ST_DONE;
          end else begin
            cyc_nxt  = v[CYC_W-1:0];
            step_nxt = (v == '0) ? ST_NUMREF : ST_CYCLEOFF;
          end
        end
        ST_CYCLEOFF: begin
          cyc_nxt = cyc_dec;
          if (cyc_dec == '0) step_nxt = ST_NUMREF;
        end
        ST_NUMREF: step_nxt = ST_GAPS;
        ST_GAPS:   step_nxt = ST_WIDTH;
        ST_WIDTH: begin
          if (v >= ACC_W'(MAX_DIM_BLOCKS)) begin
            given_nxt = 1'b1;
            stat_nxt  = STAT_RANGE;
            step_nxt  = ST_DONE;
          end else begin
            wib_nxt  = v[BLK_W-1:0] + 1'b1;
            step_nxt = ST_HEIGHT;
          end
        end
        ST_HEIGHT: begin
          given_nxt = 1'b1;
          step_nxt  = ST_DONE;
          if (v >= ACC_W'(MAX_DIM_BLOCKS)) begin
            stat_nxt = STAT_RANGE;
          end else begin
            stat_nxt = STAT_OK;
            hib_nxt  = v[BLK_W-1:0] + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // State registers; clear returns to the header step
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      step_r       <= ST_HDR;
      lzc_r        <= '0;
      acc_r        <= '0;
      prof_r       <= '0;
      list_r       <= '0;
      coef_r       <= '0;
      last_scale_r <= 8'd8;
      cyc_r        <= '0;
      wib_r        <= '0;
      given_r      <= 1'b0;
    end else begin
      step_r       <= step_nxt;
      lzc_r        <= lzc_nxt;
      acc_r        <= acc_nxt;
      prof_r       <= prof_nxt;
      list_r       <= list_nxt;
      coef_r       <= coef_nxt;
      last_scale_r <= last_scale_nxt;
      cyc_r        <= cyc_nxt;
      wib_r        <= wib_nxt;
      given_r      <= given_nxt;
    end
  end

  // Result payload, qualified by given
  always_ff @(posedge clk) begin
    stat_r <= stat_nxt;
    hib_r  <= hib_nxt;
  end

  assign res.given  = given_r;
  assign res.status = stat_r;
  assign res.wib    = wib_r;
  assign res.hib    = hib_r;

endmodule

`default_nettype wire

// ===== sv/h264_sps_dimension_parser.sv =====
// Flow: a byte is accepted and shifted through the parser one bit per cycle, and its
// result (if any) is loaded into the output register in the wrap-up state.
// Input: no new byte is taken while a byte is shifted; the next byte is taken in the
// wrap-up cycle, except when this byte has a result and the output is still full.
// Reset: synchronous active-low rst_n returns the parser to the NAL header and empties
// the output register.
// Top level of the SPS dimension parser; depends on h264sps_pkg, the interfaces and
// h264sps_bitparse.
`default_nettype none

module h264_sps_dimension_parser import h264sps_pkg::*; #(
  parameter int MAX_LEADING_ZEROS = DEF_MAX_LEADING_ZEROS,
  parameter int MAX_DIM_BLOCKS    = DEF_MAX_DIM_BLOCKS,
  parameter int MAX_POC_CYCLE     = DEF_MAX_POC_CYCLE
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  h264sps_in_if.sink    in_item,
  h264sps_out_if.source out_item
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SHIFT = 2'd1;
  localparam logic [1:0] S_WRAP  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [2:0]        bitpos_r, bitpos_nxt;
  logic [BYTE_W-1:0] sh_r, sh_nxt;
  logic              last_r, last_nxt;
  logic              had_r, had_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;
  logic [PIC_W-1:0]  out_w_r, out_w_nxt;
  logic [PIC_W-1:0]  out_h_r, out_h_nxt;

  parse_res_t pres;
  logic       accept, emit, wrap_go, bit_vld, pclr;

  // Wrap-up: decide on a result once all 8 bits are in
  assign emit    = (!had_r && pres.given) || (last_r && !pres.given);
  assign wrap_go = (state_r == S_WRAP) && (!emit || !out_valid_r || out_item.ready);
  assign in_item.ready = (state_r == S_IDLE) || wrap_go;
  assign accept  = in_item.valid && in_item.ready;
  assign bit_vld = state_r == S_SHIFT;
  assign pclr    = wrap_go && last_r;

  h264sps_bitparse #(
    .MAX_LEADING_ZEROS (MAX_LEADING_ZEROS),
    .MAX_DIM_BLOCKS    (MAX_DIM_BLOCKS),
    .MAX_POC_CYCLE     (MAX_POC_CYCLE)
  ) u_bitparse (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (pclr),
    .bit_vld (bit_vld),
    .bit_in  (sh_r[BYTE_W-1]),
    .res     (pres)
  );

  // Byte sequencer and output register
  always_comb begin
    state_nxt     = state_r;
    bitpos_nxt    = bitpos_r;
    sh_nxt        = sh_r;
    last_nxt      = last_r;
    had_nxt       = had_r;
    out_valid_nxt = out_valid_r && !out_item.ready;
    out_stat_nxt  = out_stat_r;
    out_w_nxt     = out_w_r;
    out_h_nxt     = out_h_r;

    case (state_r)
      S_IDLE: ;
      S_SHIFT: begin
        if (bitpos_r == '0) had_nxt = pres.given;
        sh_nxt     = {sh_r[BYTE_W-2:0], 1'b0};
        bitpos_nxt = bitpos_r + 3'd1;
        if (bitpos_r == 3'd7) state_nxt = S_WRAP;
      end
      S_WRAP: begin
        if (wrap_go) begin
          state_nxt = S_IDLE;
          if (emit) begin
            out_valid_nxt = 1'b1;
            if (pres.given) begin
              out_stat_nxt = pres.status;
              out_w_nxt    = (pres.status == STAT_OK) ? {pres.wib, 4'b0000} : '0;
              out_h_nxt    = (pres.status == STAT_OK) ? {pres.hib, 4'b0000} : '0;
            end else begin
              out_stat_nxt = STAT_TRUNC;
              out_w_nxt    = '0;
              out_h_nxt    = '0;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // New byte enters the shift register
    if (accept) begin
      state_nxt  = S_SHIFT;
      bitpos_nxt = '0;
      sh_nxt     = in_item.data_byte;
      last_nxt   = in_item.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bitpos_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bitpos_r    <= bitpos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r       <= sh_nxt;
    last_r     <= last_nxt;
    had_r      <= had_nxt;
    out_stat_r <= out_stat_nxt;
    out_w_r    <= out_w_nxt;
    out_h_r    <= out_h_nxt;
  end

  assign out_item.valid      = out_valid_r;
  assign out_item.status     = out_stat_r;
  assign out_item.pic_width  = out_w_r;
  assign out_item.pic_height = out_h_r;

endmodule

`default_nettype wire

// ===== sv/h264sps_chk.sv =====
// Port-level checker for the SPS dimension parser, bound to the top level.
// Depends on h264sps_pkg and h264_sps_dimension_parser.
`default_nettype none

module h264sps_chk import h264sps_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [STAT_W-1:0] status,
  input wire logic [PIC_W-1:0]  pic_width,
  input wire logic [PIC_W-1:0]  pic_height
);

  // A byte occupies the serial parser for its 8 bits
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted item");

  a_busy_eight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##8 !in_ready)
    else $error("input ready before all 8 bits were parsed");

  // Sizes only on a good result
  a_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != STAT_OK |-> pic_width == '0 && pic_height == '0)
    else $error("nonzero size on a failed result");

  // Stalled result is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(pic_width) &&
    $stable(pic_height))
    else $error("stalled result changed or dropped");

endmodule

bind h264_sps_dimension_parser h264sps_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_item.valid),
  .in_ready   (in_item.ready),
  .out_valid  (out_item.valid),
  .out_ready  (out_item.ready),
  .status     (out_item.status),
  .pic_width  (out_item.pic_width),
  .pic_height (out_item.pic_height)
);

`default_nettype wire

// ===== bench/sps_check_pkg.sv =====
`timescale 1ns / 100ps
// Expected-size tracker for the SPS dimension parser bench: a bit-serial model of the
// parser plus the queue of pending results. Depends on h264sps_pkg.
package sps_check_pkg;
  import h264sps_pkg::*;

  // Syntax codes used by both the model and the stimulus
  localparam int NAL_TYPE_SPS     = 7;
  localparam int CHROMA_444       = 3;
  localparam int POC_TYPE_LSB     = 0;
  localparam int POC_TYPE_CYCLE   = 1;
  localparam int PROFILE_BASELINE = 66;
  localparam int PROFILE_MAIN     = 77;
  localparam int NUM_HIGH         = 11;
  localparam logic [7:0] HIGH_PROFILES [NUM_HIGH] =
    '{8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86, 8'd118, 8'd128, 8'd138, 8'd144};

  // Syntax element being read
  typedef enum logic [5:0] {
    P_HEADER, P_PROFILE, P_CONSTRAINT, P_LEVEL, P_SPS_ID, P_CHROMA, P_RES_COLOR,
    P_DEPTH_LUMA, P_DEPTH_CHROMA, P_BYPASS, P_MATRIX, P_LIST_FLAG, P_DELTA,
    P_FRAME_NUM, P_POC_TYPE, P_POC_LSB, P_ALWAYS_ZERO, P_OFF_NONREF, P_OFF_TB,
    P_NUM_CYCLE, P_CYCLE_OFF, P_NUM_REF, P_GAPS, P_WIDTH, P_HEIGHT, P_DONE
  } sps_field_e;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PIC_W-1:0]  width;
    logic [PIC_W-1:0]  height;
  } pic_size_t;

  class sps_size_checker;
    sps_field_e        field;
    int unsigned       zeros;       // prefix zeros / suffix bits left / fixed bit count
    logic [31:0]       code;
    logic [7:0]        profile;     // becomes the 4:4:4 flag once chroma is read
    logic [3:0]        list_idx;
    logic [6:0]        coef_cnt;
    logic [7:0]        last_scale;
    logic [7:0]        next_scale;
    logic [7:0]        cycles_left;
    logic [BLK_W-1:0]  width_mb;
    bit                decided;
    pic_size_t         decision;
    pic_size_t         expected_sizes[$];
    int unsigned       n_checked;
    int unsigned       n_failed;
    int unsigned       status_seen[4];

    function new();
      restart();
      n_checked = 0;
      n_failed  = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void restart();
      field       = P_HEADER;
      zeros       = 0;
      code        = '0;
      profile     = '0;
      list_idx    = '0;
      coef_cnt    = '0;
      last_scale  = 8'd8;
      next_scale  = 8'd8;
      cycles_left = '0;
      width_mb    = '0;
      decided     = 1'b0;
    endfunction

    function void decide(logic [STAT_W-1:0] st, logic [PIC_W-1:0] w, logic [PIC_W-1:0] h);
      decision = '{status: st, width: w, height: h};
      decided  = 1'b1;
      field    = P_DONE;
    endfunction

    // 8 or 1 for fixed-length fields, 0 for Exp-Golomb fields
    function int fixed_bits(sps_field_e f);
      case (f)
        P_HEADER, P_PROFILE, P_CONSTRAINT, P_LEVEL: return 8;
        P_RES_COLOR, P_BYPASS, P_MATRIX, P_LIST_FLAG, P_ALWAYS_ZERO, P_GAPS: return 1;
        default: return 0;
      endcase
    endfunction

    function bit high_profile(logic [7:0] p);
      for (int i = 0; i < NUM_HIGH; i++)
        if (p == HIGH_PROFILES[i]) return 1'b1;
      return 1'b0;
    endfunction

    function void advance_list();
      list_idx = list_idx + 4'd1;
      field = (list_idx >= ((profile != 0) ? 12 : 8)) ? P_FRAME_NUM : P_LIST_FLAG;
    endfunction

    // A whole field has been read with value v
    function void end_field(logic [31:0] v);
      logic [31:0]      d;
      logic [31:0]      sum;
      logic [BLK_W-1:0] h_mb;
      code  = '0;
      zeros = 0;
      case (field)
        P_HEADER:
          if (v[4:0] != 5'(NAL_TYPE_SPS)) decide(STAT_NOTSPS, '0, '0);
          else field = P_PROFILE;
        P_PROFILE: begin
          profile = v[7:0];
          field = P_CONSTRAINT;
        end
        P_CONSTRAINT: field = P_LEVEL;
        P_LEVEL: field = P_SPS_ID;
        P_SPS_ID: field = high_profile(profile) ? P_CHROMA : P_FRAME_NUM;
        P_CHROMA: begin
          profile = (v == CHROMA_444) ? 8'd1 : 8'd0;
          field = (v == CHROMA_444) ? P_RES_COLOR : P_DEPTH_LUMA;
        end
        P_RES_COLOR: field = P_DEPTH_LUMA;
        P_DEPTH_LUMA: field = P_DEPTH_CHROMA;
        P_DEPTH_CHROMA: field = P_BYPASS;
        P_BYPASS: field = P_MATRIX;
        P_MATRIX: begin
          list_idx = '0;
          field = (v != 0) ? P_LIST_FLAG : P_FRAME_NUM;
        end
        P_LIST_FLAG:
          if (v != 0) begin
            coef_cnt   = '0;
            last_scale = 8'd8;
            next_scale = 8'd8;
            field      = P_DELTA;
          end else begin
            advance_list();
          end
        P_DELTA: begin
          // se mapping, then scale arithmetic modulo 256
          d = v[0] ? (v >> 1) + 32'd1 : 32'd0 - (v >> 1);
          sum = {24'd0, last_scale} + d;
          next_scale = sum[7:0];
          coef_cnt = coef_cnt + 7'd1;
          if (next_scale == 0 || coef_cnt >= ((list_idx < 6) ? 16 : 64)) advance_list();
          else last_scale = next_scale;
        end
        P_FRAME_NUM: field = P_POC_TYPE;
        P_POC_TYPE:
          field = (v == POC_TYPE_LSB) ? P_POC_LSB :
                  (v == POC_TYPE_CYCLE) ? P_ALWAYS_ZERO : P_NUM_REF;
        P_POC_LSB: field = P_NUM_REF;
        P_ALWAYS_ZERO: field = P_OFF_NONREF;
        P_OFF_NONREF: field = P_OFF_TB;
        P_OFF_TB: field = P_NUM_CYCLE;
        P_NUM_CYCLE:
          if (v > DEF_MAX_POC_CYCLE) begin
            decide(STAT_RANGE, '0, '0);
          end else begin
            cycles_left = v[7:0];
            field = (v == 0) ? P_NUM_REF : P_CYCLE_OFF;
          end
        P_CYCLE_OFF: begin
          cycles_left = cycles_left - 8'd1;
          if (cycles_left == 0) field = P_NUM_REF;
        end
        P_NUM_REF: field = P_GAPS;
        P_GAPS: field = P_WIDTH;
        P_WIDTH:
          if (v >= DEF_MAX_DIM_BLOCKS) begin
            decide(STAT_RANGE, '0, '0);
          end else begin
            width_mb = v[BLK_W-1:0] + 1'b1;
            field = P_HEIGHT;
          end
        P_HEIGHT:
          if (v >= DEF_MAX_DIM_BLOCKS) begin
            decide(STAT_RANGE, '0, '0);
          end else begin
            h_mb = v[BLK_W-1:0] + 1'b1;
            decide(STAT_OK, {width_mb, 4'b0}, {h_mb, 4'b0});
          end
        default: ;
      endcase
    endfunction

    function void shift_bit(bit b);
      int w;
      if (decided || field == P_DONE) return;
      w = fixed_bits(field);
      if (w != 0) begin
        code = {code[30:0], b};
        zeros++;
        if (zeros >= w) end_field(code);
      end else if (code == 0) begin
        // counting the Exp-Golomb prefix
        if (!b) begin
          zeros++;
          if (zeros > DEF_MAX_LEADING_ZEROS) decide(STAT_RANGE, '0, '0);
        end else begin
          code = 32'd1;
          if (zeros == 0) end_field(32'd0);
        end
      end else begin
        code = {code[30:0], b};
        zeros--;
        if (zeros == 0) end_field(code - 32'd1);
      end
    endfunction

    // One accepted byte: parse it MSB first and queue the result it causes
    function void note_byte(logic [7:0] b, logic last);
      bit had;
      bit emit;
      had  = decided;
      emit = 1'b0;
      for (int i = 7; i >= 0; i--) shift_bit(b[i]);
      if (!had && decided) emit = 1'b1;
      if (last && !decided) begin
        decide(STAT_TRUNC, '0, '0);
        emit = 1'b1;
      end
      if (emit) expected_sizes.push_back(decision);
      if (last) restart();
    endfunction

    function void check_result(logic [STAT_W-1:0] st, logic [PIC_W-1:0] w,
                               logic [PIC_W-1:0] h);
      pic_size_t want;
      if (expected_sizes.size() == 0) begin
        $display("%0t: unexpected result status %0d width %0d height %0d", $time, st, w, h);
        n_failed++;
        return;
      end
      want = expected_sizes.pop_front();
      n_checked++;
      status_seen[want.status]++;
      if (want.status != st) begin
        $display("%0t: status expected %0d got %0d", $time, want.status, st);
        n_failed++;
      end
      if (want.width != w) begin
        $display("%0t: pic_width expected %0d got %0d", $time, want.width, w);
        n_failed++;
      end
      if (want.height != h) begin
        $display("%0t: pic_height expected %0d got %0d", $time, want.height, h);
        n_failed++;
      end
    endfunction

    function int pending();
      return expected_sizes.size();
    endfunction

    function void close();
      if (expected_sizes.size() != 0) begin
        $display("%0t: %0d expected results never arrived", $time, expected_sizes.size());
        n_failed += expected_sizes.size();
      end
    endfunction
  endclass

endpackage

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the SPS dimension parser bench: builds SPS NAL units bit by bit, drives them
// with random gaps and checks each result. Depends on h264sps_pkg, the interfaces and sps_check_pkg.
module tb_top;
  import h264sps_pkg::*;
  import sps_check_pkg::*;

  localparam int RANDOM_BYTES = 1700;
  localparam int HOLD_CYCLES  = 400;

  logic clk;
  logic rst_n;

  h264sps_in_if  in_if();
  h264sps_out_if out_if();

  h264_sps_dimension_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_if),
    .out_item (out_if)
  );

  sps_size_checker sizes;

  bit         nal_bits[$];
  logic [8:0] nal_bytes[$];   // {last, byte}
  int         ue_calls;
  int         ue_fault_at;
  int         bytes_sent;
  int         nals_sent;
  bit         hold_out;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", sizes.pending());
    $display("simulation failed");
    $finish;
  end

  // ---- bit writer ----
  function automatic void put_bits(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) nal_bits.push_back(v[i]);
  endfunction

  function automatic void put_ue(logic [31:0] v);
    logic [32:0] cw;
    int n;
    cw = {1'b0, v} + 33'd1;
    n = 32;
    while (!cw[n]) n--;
    repeat (n) nal_bits.push_back(1'b0);
    for (int i = n; i >= 0; i--) nal_bits.push_back(cw[i]);
  endfunction

  function automatic void put_se(int v);
    if (v > 0) put_ue(32'(2 * v - 1));
    else put_ue(32'(-2 * v));
  endfunction

  // ue field, possibly replaced by a 31-zero or a too-long code
  function automatic void put_field(int unsigned v);
    if (ue_calls == ue_fault_at) begin
      if ($urandom_range(0, 1)) put_ue(32'hFFFF_FFFF);
      else put_ue(32'h7FFF_FFFF + $urandom_range(0, 32'h7FFF_FFFF));
    end else begin
      put_ue(v);
    end
    ue_calls++;
  endfunction

  function automatic int unsigned pick_dim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 72) return $urandom_range(0, 127);
    if (r < 82) return $urandom_range(128, DEF_MAX_DIM_BLOCKS - 1);
    if (r < 88) return DEF_MAX_DIM_BLOCKS - 1;
    if (r < 94) return DEF_MAX_DIM_BLOCKS;
    return $urandom_range(DEF_MAX_DIM_BLOCKS + 1, 200000);
  endfunction

  // Scaling list deltas that follow the last/next scale rule
  function automatic void put_scaling_list(int size);
    int count;
    int stop_at;
    int d;
    int last_s;
    count   = size;
    stop_at = -1;
    if ($urandom_range(0, 99) < 80) begin
      count   = $urandom_range(1, (size == 16) ? 16 : 12);
      stop_at = count - 1;
    end
    last_s = 8;
    for (int j = 0; j < count; j++) begin
      if (j == stop_at) begin
        d = $urandom_range(0, 1) ? -last_s : 256 - last_s;
      end else begin
        d = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 255)) - 128
                                        : int'($urandom_range(0, 16)) - 8;
        if (((last_s + d) & 255) == 0) d++;
      end
      put_se(d);
      last_s = (last_s + d) & 255;
    end
  endfunction

  // Build one SPS; negative arguments are drawn at random. With messy set, some units
  // carry bad codes, junk tails or are cut short.
  function automatic void gen_sps(int prof, int wmb, int hmb, bit messy);
    logic [7:0]  p;
    int unsigned chroma;
    int unsigned poc;
    int unsigned ncyc;
    int unsigned r;
    int          cut;
    logic [7:0]  b;
    nal_bits.delete();
    ue_calls    = 0;
    ue_fault_at = (messy && $urandom_range(0, 99) < 8) ? $urandom_range(0, 10) : -1;

    put_bits({3'($urandom_range(0, 7)), 5'(NAL_TYPE_SPS)}, 8);
    r = $urandom_range(0, 99);
    if (prof >= 0) p = 8'(prof);
    else if (r < 50) p = HIGH_PROFILES[$urandom_range(0, NUM_HIGH - 1)];
    else if (r < 70) p = 8'(PROFILE_BASELINE);
    else if (r < 80) p = 8'(PROFILE_MAIN);
    else p = 8'($urandom);
    put_bits(p, 8);
    put_bits($urandom, 8);
    put_bits($urandom, 8);
    put_field($urandom_range(0, 31));

    // high profile extension
    if (sizes.high_profile(p)) begin
      chroma = (messy && $urandom_range(0, 99) < 8) ? $urandom_range(4, 20)
                                                     : $urandom_range(0, 3);
      put_field(chroma);
      if (chroma == CHROMA_444) put_bits($urandom, 1);
      put_field($urandom_range(0, 8));
      put_field($urandom_range(0, 8));
      put_bits($urandom, 1);
      if ($urandom_range(0, 99) < 35) begin
        put_bits(1, 1);
        for (int i = 0; i < ((chroma == CHROMA_444) ? 12 : 8); i++) begin
          if ($urandom_range(0, 99) < 40) begin
            put_bits(1, 1);
            put_scaling_list((i < 6) ? 16 : 64);
          end else begin
            put_bits(0, 1);
          end
        end
      end else begin
        put_bits(0, 1);
      end
    end

    put_field($urandom_range(0, 12));
    r = $urandom_range(0, 99);
    poc = (r < 40) ? POC_TYPE_LSB : (r < 75) ? POC_TYPE_CYCLE :
          (r < 92) ? 2 : $urandom_range(3, 40);
    put_field(poc);
    if (poc == POC_TYPE_LSB) begin
      put_field($urandom_range(0, 12));
    end else if (poc == POC_TYPE_CYCLE) begin
      put_bits($urandom, 1);
      put_se(int'($urandom_range(0, 200)) - 100);
      put_se(int'($urandom_range(0, 200)) - 100);
      r = $urandom_range(0, 99);
      ncyc = (r < 75) ? $urandom_range(0, 4) : (r < 80) ? DEF_MAX_POC_CYCLE :
             (r < 90) ? $urandom_range(DEF_MAX_POC_CYCLE + 1, DEF_MAX_POC_CYCLE + 40)
                      : $urandom_range(5, 30);
      put_field(ncyc);
      if (ncyc <= DEF_MAX_POC_CYCLE)
        repeat (ncyc)
          put_se((ncyc < 20 || $urandom_range(0, 9) == 0) ? int'($urandom_range(0, 64)) - 32
                                                          : 0);
    end
    put_field($urandom_range(0, 16));
    put_bits($urandom, 1);
    put_field((wmb >= 0) ? wmb : pick_dim());
    put_field((hmb >= 0) ? hmb : pick_dim());

    // stop bit and byte alignment
    nal_bits.push_back(1'b1);
    while (nal_bits.size() % 8 != 0) nal_bits.push_back(1'b0);
    while (nal_bits.size() != 0) begin
      for (int k = 0; k < 8; k++) b = {b[6:0], nal_bits.pop_front()};
      nal_bytes.push_back({1'b0, b});
    end
    if (messy && $urandom_range(0, 99) < 20)
      repeat ($urandom_range(1, 3)) nal_bytes.push_back({1'b0, 8'($urandom)});
    if (messy && nal_bytes.size() > 1 && $urandom_range(0, 99) < 12) begin
      cut = $urandom_range(1, nal_bytes.size() - 1);
      nal_bytes = nal_bytes[0:cut-1];
    end
    nal_bytes[nal_bytes.size()-1][8] = 1'b1;
  endfunction

  // Random bytes; the header is sometimes an SPS one so the content gets parsed
  function automatic void gen_noise();
    int n;
    n = $urandom_range(1, 6);
    if ($urandom_range(0, 99) < 30)
      nal_bytes.push_back({1'b0, 3'($urandom_range(0, 7)), 5'(NAL_TYPE_SPS)});
    else
      nal_bytes.push_back({1'b0, 8'($urandom)});
    repeat (n - 1) nal_bytes.push_back({1'b0, 8'($urandom)});
    nal_bytes[nal_bytes.size()-1][8] = 1'b1;
  endfunction

  // One-byte unit of some other NAL type
  function automatic void gen_other_nal();
    int unsigned t;
    t = $urandom_range(0, 30);
    if (t >= NAL_TYPE_SPS) t++;
    nal_bytes.push_back({1'b1, 3'($urandom_range(0, 7)), 5'(t)});
  endfunction

  // ---- driving ----
  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic send_byte(input logic [8:0] item, input int idle);
    if (idle > 0) begin
      in_if.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= item[7:0];
    in_if.last_byte <= item[8];
    do @(posedge clk); while (!in_if.ready);
    bytes_sent++;
  endtask

  task automatic send_nal(input bit no_gaps);
    bit burst;
    burst = no_gaps || ($urandom_range(0, 99) < 30);
    while (nal_bytes.size() != 0)
      send_byte(nal_bytes.pop_front(), burst ? 0 : $urandom_range(0, 19));
    nals_sent++;
  endtask

  // Result side: random stalls, quiet stretches and one long hold-off
  initial begin : result_sink
    int stall;
    int quiet_left;
    quiet_left = 0;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_out) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        if (quiet_left > 0) begin
          stall = 0;
          quiet_left--;
        end else begin
          stall = $urandom_range(0, 19);
          if ($urandom_range(0, 15) == 0) quiet_left = 12;
        end
        if (stall > 0) begin
          out_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  // Accepted items on both sides
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      sizes.note_byte(in_if.data_byte, in_if.last_byte);
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sizes.check_result(out_if.status, out_if.pic_width, out_if.pic_height);
  end

  initial begin : stimulus
    int unsigned r;
    int          waited;
    sizes      = new();
    bytes_sent = 0;
    nals_sent  = 0;
    hold_out   = 1'b0;
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.data_byte <= '0;
    in_if.last_byte <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: other NAL types, header-only unit, over-long code, largest picture
    nal_bytes.push_back({1'b1, 8'h00});
    send_nal(0);
    nal_bytes.push_back({1'b1, 3'b011, 5'(NAL_TYPE_SPS)});
    send_nal(0);
    nal_bytes = '{{1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b1, 8'h00}};
    send_nal(0);
    nal_bytes = '{{1'b0, 3'b011, 5'(NAL_TYPE_SPS)}, {1'b0, 8'(PROFILE_BASELINE)},
                  {1'b0, 8'h00}, {1'b0, 8'h1E}, {1'b0, 8'h00}, {1'b0, 8'h00},
                  {1'b0, 8'h00}, {1'b1, 8'h00}};
    send_nal(0);
    gen_sps(PROFILE_BASELINE, DEF_MAX_DIM_BLOCKS - 1, DEF_MAX_DIM_BLOCKS - 1, 1'b0);
    send_nal(0);

    // back-to-back short units while the result side holds off
    hold_out = 1'b1;
    repeat (10) begin
      gen_other_nal();
      send_nal(1);
    end

    // random traffic, mostly well-formed SPS units
    while (bytes_sent < RANDOM_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 12) gen_noise();
      else if (r < 20) gen_other_nal();
      else gen_sps(-1, -1, -1, 1'b1);
      send_nal(0);
    end
    in_if.valid <= 1'b0;

    waited = 0;
    while (sizes.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (30) @(posedge clk);
    sizes.close();

    $display("covered %0d NAL units in %0d bytes: %0d sized, %0d not SPS, %0d truncated, %0d over range",
             nals_sent, bytes_sent, sizes.status_seen[STAT_OK], sizes.status_seen[STAT_NOTSPS],
             sizes.status_seen[STAT_TRUNC], sizes.status_seen[STAT_RANGE]);
    $display("%0d results compared, %0d mismatches", sizes.n_checked, sizes.n_failed);
    if (sizes.n_failed == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
